// File: src/rer_pkg.sv
// Package with the shared types and codes of the rotary encoder step reporter.
`default_nettype none

package rer_pkg;

  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] REPORT_TICKS_RESET = 16'd50;

  typedef enum logic [1:0] {
    DT_IDLE = 2'd0,
    DT_CW   = 2'd1,
    DT_CCW  = 2'd2,
    DT_WAIT = 2'd3
  } detent_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PUSH_CW  = 2'd1,
    PH_PUSH_CCW = 2'd2,
    PH_DELAY    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  // Detent events from the tracker for the current tick.
  typedef struct packed {
    logic cw;
    logic ccw;
  } detent_evt_t;

endpackage

`default_nettype wire

// File: src/rer_channels_if.sv
// Valid/ready channel interfaces for the pin, report and configuration transfers.
`default_nettype none

interface rer_pin_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

interface rer_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] report_state;
  modport source (output valid, output report_state, input ready);
  modport sink   (input valid, input report_state, output ready);
endinterface

interface rer_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rer_pkg::CFG_WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/rer_detent_tracker.sv
// Detent tracker: follows the pin lead and flags a completed detent.
`default_nettype none

module rer_detent_tracker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 pin_a,
  input  wire logic                 pin_b,
  output rer_pkg::detent_evt_t      evt
);

  rer_pkg::detent_t state_r;
  rer_pkg::detent_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    evt       = '0;
    if (pin_a && !pin_b && state_r == rer_pkg::DT_IDLE) begin
      state_nxt = rer_pkg::DT_CW;
    end else if (!pin_a && pin_b && state_r == rer_pkg::DT_IDLE) begin
      state_nxt = rer_pkg::DT_CCW;
    end else if (!pin_a && !pin_b && state_r == rer_pkg::DT_CW) begin
      evt.cw    = 1'b1;
      state_nxt = rer_pkg::DT_WAIT;
    end else if (!pin_a && !pin_b && state_r == rer_pkg::DT_CCW) begin
      evt.ccw   = 1'b1;
      state_nxt = rer_pkg::DT_WAIT;
    end else if (pin_a && pin_b) begin
      state_nxt = rer_pkg::DT_IDLE;
    end
  end

  // Advance only when the sampled pins are consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rer_pkg::DT_IDLE;
    end else if (en) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/rotary_encoder_step_reporter.sv
// Top level of the rotary encoder step reporter.
`default_nettype none

// Takes one sampled pin pair (pin_a, pin_b) per transfer, one per tick, and
// returns one report_state per transfer: 0 idle, 1 push clockwise, 2 push
// counter-clockwise, 3 delay. A detent is a single-pin lead followed by
// both pins low; it is held as one pending direction until the report
// machine is idle, which then holds the push phase and the delay phase for
// report_ticks + 1 ticks each. A newer detent overwrites an older pending
// one. The block sustains one transfer per clock cycle while the output is
// ready; each transfer goes through the input register, then the result
// register, and the whole update of one tick is a single pass of short
// next-state logic between them. The input register keeps taking transfers
// while a result waits, until both stages are full. report_ticks resets to
// 50 and is truncated to COUNTER_WIDTH bits when loaded; write it only
// while no transfer is in flight.
module rotary_encoder_step_reporter #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  rer_pin_if.sink     in_ch,
  rer_report_if.source out_ch,
  rer_cfg_if.sink     cfg_ch
);

  // Configuration register; always ready.
  logic [rer_pkg::CFG_WIDTH-1:0] report_ticks_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_ticks_r <= rer_pkg::REPORT_TICKS_RESET;
    end else if (cfg_ch.valid) begin
      report_ticks_r <= cfg_ch.data;
    end
  end

  // Zero-extend to 32 bits, then keep the counter's low bits.
  logic [31:0]              ticks_ext;
  logic [COUNTER_WIDTH-1:0] load_val;

  assign ticks_ext = {{(32 - rer_pkg::CFG_WIDTH){1'b0}}, report_ticks_r};
  assign load_val  = ticks_ext[COUNTER_WIDTH-1:0];

  // Input register stage.
  logic s1_valid_r;
  logic s1_pin_a_r;
  logic s1_pin_b_r;
  logic out_valid_r;
  logic adv;

  // Process the held pins when the result register is free or draining.
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_pin_a_r <= in_ch.pin_a;
      s1_pin_b_r <= in_ch.pin_b;
    end
  end

  // Detent tracker.
  rer_pkg::detent_evt_t det_evt;

  rer_detent_tracker u_detent (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .pin_a (s1_pin_a_r),
    .pin_b (s1_pin_b_r),
    .evt   (det_evt)
  );

  // Report machine: pending direction, phase and tick counter.
  rer_pkg::dir_t            pend_r;
  rer_pkg::dir_t            pend_nxt;
  rer_pkg::dir_t            pend_det;
  rer_pkg::phase_t          phase_r;
  rer_pkg::phase_t          phase_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_r;
  logic [COUNTER_WIDTH-1:0] cnt_nxt;

  always_comb begin
    // Latest detent of this tick overrides any older pending one.
    if (det_evt.cw) begin
      pend_det = rer_pkg::DIR_CW;
    end else if (det_evt.ccw) begin
      pend_det = rer_pkg::DIR_CCW;
    end else begin
      pend_det = pend_r;
    end

    pend_nxt  = pend_det;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;

    if (phase_r == rer_pkg::PH_IDLE) begin
      if (pend_det != rer_pkg::DIR_NONE) begin
        // Take the pending direction; an unknown code leaves the phase idle.
        case (pend_det)
          rer_pkg::DIR_CW:  phase_nxt = rer_pkg::PH_PUSH_CW;
          rer_pkg::DIR_CCW: phase_nxt = rer_pkg::PH_PUSH_CCW;
          default:          phase_nxt = rer_pkg::PH_IDLE;
        endcase
        pend_nxt = rer_pkg::DIR_NONE;
        cnt_nxt  = load_val;
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      case (phase_r)
        rer_pkg::PH_PUSH_CW,
        rer_pkg::PH_PUSH_CCW: begin
          phase_nxt = rer_pkg::PH_DELAY;
          cnt_nxt   = load_val;
        end
        default: phase_nxt = rer_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= rer_pkg::DIR_NONE;
      phase_r <= rer_pkg::PH_IDLE;
      cnt_r   <= '0;
    end else if (adv) begin
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register: load on advance, drop on transfer.
  logic [1:0] report_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      report_r <= phase_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.report_state = report_r;

  // Checks on the report machine and the input stage.
  a_push_cw_exit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == rer_pkg::PH_PUSH_CW
      |=> phase_r == rer_pkg::PH_PUSH_CW || phase_r == rer_pkg::PH_DELAY)
    else $error("push clockwise left for a phase other than delay");

  a_delay_exit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == rer_pkg::PH_DELAY
      |=> phase_r == rer_pkg::PH_DELAY || phase_r == rer_pkg::PH_IDLE)
    else $error("delay left for a phase other than idle");

  a_pend_taken: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == rer_pkg::PH_IDLE && phase_nxt != rer_pkg::PH_IDLE
      |=> pend_r == rer_pkg::DIR_NONE)
    else $error("pending direction not cleared when a push started");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_pin_a_r) && $stable(s1_pin_b_r))
    else $error("input stage lost a held item");

endmodule

`default_nettype wire
